>>> sv/lsa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsa_pkg
// Shared types and default sizes for the least recently used slot allocator.
// ----------------------------------------------------------------------------
package lsa_pkg;

  localparam int unsigned SlotsDef     = 16;
  localparam int unsigned IdBitsDef    = 8;
  localparam int unsigned TimeBitsDef  = 32;

  localparam int unsigned OpcodeW      = 2;
  localparam int unsigned ObjectIdW    = 8;
  localparam int unsigned NowTimeW     = 32;
  localparam int unsigned SlotIndexW   = 4;
  localparam int unsigned EvictedIdW   = 8;

  typedef enum logic [OpcodeW-1:0] {
    OP_ACCESS  = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PURGE   = 2'd2,
    OP_NOP     = 2'd3
  } lsa_op_e;

endpackage
`default_nettype wire

>>> sv/lru_slot_allocator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lru_slot_allocator_unit
// Fully associative residency table with least recently used replacement.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Every command
// (access, release, purge or no-op) runs the whole sweep: the single read
// port of the owner and stamp table is swept one entry per cycle, the drain
// state finishes the last compare and the finish state writes back. The
// result beat is registered by the finish state and shows on result_valid_o
// for one cycle; busy_o is already low in that cycle, so the next command
// may be taken at the edge that ends it. There is no back-pressure on
// results: the receiver must take every beat when shown.
// ----------------------------------------------------------------------------
module lru_slot_allocator_unit
  import lsa_pkg::*;
#(
  parameter int unsigned SLOTS     = SlotsDef,
  parameter int unsigned ID_BITS   = IdBitsDef,
  parameter int unsigned TIME_BITS = TimeBitsDef
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire logic [OpcodeW-1:0]    opcode_i,
  input  wire logic [ObjectIdW-1:0]  object_id_i,
  input  wire logic [NowTimeW-1:0]   now_time_i,
  output logic                       result_valid_o,
  output logic                       hit_o,
  output logic [SlotIndexW-1:0]      slot_index_o,
  output logic                       took_free_o,
  output logic                       evicted_o,
  output logic [EvictedIdW-1:0]      evicted_id_o
);

  localparam int unsigned IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef logic [IdxW-1:0]      idx_t;
  typedef logic [ID_BITS-1:0]   id_t;
  typedef logic [TIME_BITS-1:0] stamp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_e;

  state_e          state_q;
  lsa_op_e         op_q;
  id_t             id_q;
  stamp_t          now_q;
  logic [SLOTS-1:0] used_q;

  idx_t            ptr_q;
  logic            rd_vld_q;
  idx_t            rd_idx_q;
  id_t             rd_owner_q;
  stamp_t          rd_stamp_q;

  logic            found_q;
  idx_t            found_idx_q;
  logic            free_q;
  idx_t            free_idx_q;
  logic            min_vld_q;
  idx_t            min_idx_q;
  stamp_t          min_stamp_q;
  id_t             min_owner_q;

  logic            valid_q;
  logic            hit_q;
  idx_t            slot_q;
  logic            took_free_q;
  logic            evicted_q;
  id_t             evicted_id_q;

  id_t             owner_mem [SLOTS];
  stamp_t          stamp_mem [SLOTS];

  // write-back decision
  logic            owner_we;
  logic            stamp_we;
  idx_t            wr_idx;
  logic            res_hit;
  logic            res_free;
  logic            res_evict;
  idx_t            res_slot;
  id_t             res_evict_id;
  logic            rd_used;
  logic            rd_match;
  logic            accept;

  assign busy_o  = (state_q != ST_IDLE);
  assign accept  = start_i && !busy_o;
  assign rd_used = used_q[rd_idx_q];
  assign rd_match = rd_used && (rd_owner_q == id_q);

  always_comb begin
    owner_we     = 1'b0;
    stamp_we     = 1'b0;
    wr_idx       = found_idx_q;
    res_hit      = 1'b0;
    res_free     = 1'b0;
    res_evict    = 1'b0;
    res_slot     = '0;
    res_evict_id = '0;
    if (state_q == ST_FINISH) begin
      unique case (op_q)
        OP_ACCESS: begin
          stamp_we = 1'b1;
          if (found_q) begin
            res_hit  = 1'b1;
            res_slot = found_idx_q;
            wr_idx   = found_idx_q;
          end else if (free_q) begin
            res_free = 1'b1;
            owner_we = 1'b1;
            res_slot = free_idx_q;
            wr_idx   = free_idx_q;
          end else begin
            res_evict    = 1'b1;
            owner_we     = 1'b1;
            res_slot     = min_idx_q;
            res_evict_id = min_owner_q;
            wr_idx       = min_idx_q;
          end
        end
        OP_RELEASE: begin
          if (found_q) begin
            res_hit  = 1'b1;
            res_slot = found_idx_q;
          end
        end
        OP_PURGE, OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // owner and stamp table, one read port swept by the scan pointer
  always_ff @(posedge clk_i) begin
    if (owner_we) begin
      owner_mem[wr_idx] <= id_q;
    end
    if (stamp_we) begin
      stamp_mem[wr_idx] <= now_q;
    end
    rd_owner_q <= owner_mem[ptr_q];
    rd_stamp_q <= stamp_mem[ptr_q];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= lsa_op_e'(opcode_i);
      id_q  <= ID_BITS'(object_id_i);
      now_q <= TIME_BITS'(now_time_i);
    end
    if (state_q == ST_SCAN) begin
      rd_idx_q <= ptr_q;
    end
    if (rd_vld_q) begin
      if (rd_match && !found_q) begin
        found_idx_q <= rd_idx_q;
      end
      if (!rd_used && !free_q) begin
        free_idx_q <= rd_idx_q;
      end
      if (rd_used && (!min_vld_q || (rd_stamp_q < min_stamp_q))) begin
        min_idx_q   <= rd_idx_q;
        min_stamp_q <= rd_stamp_q;
        min_owner_q <= rd_owner_q;
      end
    end
    if (state_q == ST_FINISH) begin
      hit_q        <= res_hit;
      slot_q       <= res_slot;
      took_free_q  <= res_free;
      evicted_q    <= res_evict;
      evicted_id_q <= res_evict_id;
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      used_q    <= '0;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      min_vld_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      valid_q  <= 1'b0;
      rd_vld_q <= (state_q == ST_SCAN);
      if (rd_vld_q) begin
        if (rd_match) begin
          found_q <= 1'b1;
        end
        if (!rd_used) begin
          free_q <= 1'b1;
        end
        if (rd_used) begin
          min_vld_q <= 1'b1;
        end
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            state_q   <= ST_SCAN;
            ptr_q     <= '0;
            found_q   <= 1'b0;
            free_q    <= 1'b0;
            min_vld_q <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (ptr_q == IdxW'(SLOTS - 1)) begin
            state_q <= ST_DRAIN;
          end else begin
            ptr_q <= ptr_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_FINISH;
        end
        ST_FINISH: begin
          state_q <= ST_IDLE;
          valid_q <= 1'b1;
          priority if (op_q == OP_PURGE) begin
            used_q <= '0;
          end else if ((op_q == OP_RELEASE) && found_q) begin
            used_q[found_idx_q] <= 1'b0;
          end else if ((op_q == OP_ACCESS) && !found_q && free_q) begin
            used_q[free_idx_q] <= 1'b1;
          end else begin
            used_q <= used_q;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign hit_o          = hit_q;
  assign slot_index_o   = SlotIndexW'(slot_q);
  assign took_free_o    = took_free_q;
  assign evicted_o      = evicted_q;
  assign evicted_id_o   = EvictedIdW'(evicted_id_q);

`ifndef SYNTHESIS
  a_beat_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == ST_FINISH))
    else $error("result beat without a write-back cycle");

  a_outcome_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ($countones({hit_o, took_free_o, evicted_o}) <= 1))
    else $error("more than one outcome flagged in a beat");

  a_purge_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (op_q == OP_PURGE)) |-> (used_q == '0))
    else $error("used flags left set after purge");

  a_evict_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && op_q == OP_ACCESS && !found_q && !free_q) |->
      (used_q == '1))
    else $error("eviction chosen while a slot is free");

  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_o && !result_valid_o))
    else $error("command taken without entering the scan");
`endif

endmodule
`default_nettype wire
